// File: rtl/sir_afw_pkg.sv
package sir_afw_pkg;

   localparam logic [7:0] CE_BYTE       = 8'h7D;
   localparam logic [7:0] BOF_BYTE      = 8'hC0;
   localparam logic [7:0] EOF_BYTE      = 8'hC1;
   localparam logic [7:0] ESC_XOR       = 8'h20;
   localparam logic [7:0] XBOF_BYTE     = 8'hFF;
   localparam logic [5:0] MAX_EXTRA_BOF = 6'd48;
   localparam logic [15:0] CRC_POLY     = 16'h8408;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_frame;
      logic       last_of_frame;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_end;
   } rsp_type;

   // classified work item handed from front to back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_of_frame;
      logic        last_of_frame;
      logic [5:0]  bof_count;
      logic [15:0] fcs;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // reflected CRC-16-CCITT, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == CE_BYTE) || (b == BOF_BYTE) || (b == EOF_BYTE);
   endfunction

endpackage

// File: rtl/sir_afw_front.sv
module sir_afw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sir_afw_pkg::req_type req_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [5:0]           csr_data,
   input  logic                 queue_full,
   output sir_afw_pkg::push_type push
);
   import sir_afw_pkg::*;

   logic [5:0]  extra_bof_ff, extra_bof_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic [5:0]  bof_sat;
   logic        accept;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign bof_sat  = (extra_bof_ff > MAX_EXTRA_BOF) ? MAX_EXTRA_BOF : extra_bof_ff;
   assign crc_base = req_payload.first_of_frame ? CRC_INIT : crc_ff;
   assign crc_next = crc_byte(crc_base, req_payload.data_byte);

   always_comb begin
      extra_bof_in = extra_bof_ff;
      if (csr_valid && csr_ready) begin
         extra_bof_in = csr_data;
      end
      crc_in = crc_ff;
      if (accept) begin
         crc_in = req_payload.last_of_frame ? CRC_INIT : crc_next;
      end
   end

   always_comb begin
      push.push                 = accept;
      push.entry.data_byte      = req_payload.data_byte;
      push.entry.first_of_frame = req_payload.first_of_frame;
      push.entry.last_of_frame  = req_payload.last_of_frame;
      push.entry.bof_count      = req_payload.first_of_frame ? bof_sat : 6'd0;
      push.entry.fcs            = ~crc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extra_bof_ff <= 6'd0;
         crc_ff       <= CRC_INIT;
      end else begin
         extra_bof_ff <= extra_bof_in;
         crc_ff       <= crc_in;
      end
   end

endmodule

// File: rtl/sir_afw_queue.sv
module sir_afw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  sir_afw_pkg::push_type push,
   output logic                  full,
   output sir_afw_pkg::head_type head,
   input  logic                  pop
);
   import sir_afw_pkg::*;

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push    = push.push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/sir_afw_back.sv
module sir_afw_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sir_afw_pkg::head_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sir_afw_pkg::rsp_type  rsp_payload
);
   import sir_afw_pkg::*;

   typedef enum logic [6:0] {
      ST_START  = 7'b0000001,
      ST_XBOF   = 7'b0000010,
      ST_BOF    = 7'b0000100,
      ST_DATA   = 7'b0001000,
      ST_FCS_LO = 7'b0010000,
      ST_FCS_HI = 7'b0100000,
      ST_EOF    = 7'b1000000
   } phase_type;

   phase_type  phase_ff, phase_in;
   phase_type  cur;
   logic [5:0] cnt_ff, cnt_in;
   logic       esc_ff, esc_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       emit;
   logic       run_end;
   logic       is_eof;
   logic [7:0] src;
   logic [7:0] line_byte;
   phase_type  adv;

   assign emit = head.valid && (!out_valid_ff || rsp_ready);
   assign pop  = emit && run_end;

   // effective phase: a fresh entry picks its own starting point
   always_comb begin
      cur = phase_ff;
      if (phase_ff == ST_START) begin
         if (head.entry.first_of_frame && (head.entry.bof_count != 6'd0)) begin
            cur = ST_XBOF;
         end else if (head.entry.first_of_frame) begin
            cur = ST_BOF;
         end else begin
            cur = ST_DATA;
         end
      end
   end

   always_comb begin
      case (cur)
         ST_FCS_LO: src = head.entry.fcs[7:0];
         ST_FCS_HI: src = head.entry.fcs[15:8];
         default:   src = head.entry.data_byte;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      esc_in    = esc_ff;
      run_end   = 1'b0;
      is_eof    = 1'b0;
      line_byte = src;
      adv       = ST_START;
      unique case (cur)
         ST_XBOF: begin
            line_byte = XBOF_BYTE;
            if (6'(cnt_ff + 6'd1) == head.entry.bof_count) begin
               cnt_in   = 6'd0;
               phase_in = ST_BOF;
            end else begin
               cnt_in   = 6'(cnt_ff + 6'd1);
               phase_in = ST_XBOF;
            end
         end
         ST_BOF: begin
            line_byte = BOF_BYTE;
            phase_in  = ST_DATA;
         end
         ST_EOF: begin
            line_byte = EOF_BYTE;
            is_eof    = 1'b1;
            run_end   = 1'b1;
            phase_in  = ST_START;
         end
         default: begin
            // data or FCS byte, escaped when it collides with a framing code
            if (cur == ST_DATA) begin
               adv = head.entry.last_of_frame ? ST_FCS_LO : ST_START;
            end else if (cur == ST_FCS_LO) begin
               adv = ST_FCS_HI;
            end else begin
               adv = ST_EOF;
            end
            if (needs_escape(src) && !esc_ff) begin
               line_byte = CE_BYTE;
               esc_in    = 1'b1;
               phase_in  = cur;
            end else begin
               line_byte = esc_ff ? (src ^ ESC_XOR) : src;
               esc_in    = 1'b0;
               phase_in  = adv;
               run_end   = (adv == ST_START);
            end
         end
      endcase
   end

   always_comb begin
      out_in.out_byte    = line_byte;
      out_in.last_of_run = run_end;
      out_in.frame_end   = is_eof;
      out_valid_in       = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_START;
         cnt_ff       <= 6'd0;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (emit) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            esc_ff   <= esc_in;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_cnt_only_in_xbof: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 6'd0) |-> (phase_ff == ST_XBOF))
      else $error("extra BOF count live outside extra BOF phase");

   a_esc_phase: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (phase_ff == ST_DATA || phase_ff == ST_FCS_LO || phase_ff == ST_FCS_HI))
      else $error("escape pending outside an escapable phase");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      pop |=> (phase_ff == ST_START && !esc_ff))
      else $error("entry retired without returning to start");

   a_eof_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.frame_end) |-> rsp_payload.last_of_run)
      else $error("EOF not marked as end of run");

endmodule

// File: rtl/sir_async_frame_wrapper_core.sv
// IrDA SIR async frame wrapper.
// req_*: one raw frame byte per transfer with first/last-of-frame marks.
// csr_*: write of the extra BOF count (6 bits, values above 48 act as 48);
//   always ready, change it only while the block is idle.
// rsp_*: one line byte per transfer; last_of_run marks the final byte caused
//   by an input byte, frame_end marks the closing EOF.
// Front: CRC-16 (IrDA) update, classify, one byte per cycle unless queue full.
// A 4-entry queue decouples the front from the back-end byte sequencer.
// Back: emits extra BOFs, BOF, escaped data, escaped FCS and EOF, one line
//   byte per cycle unless the output stalls, into a registered output.
// On an idle block a req transfer goes into the queue, then into the output
//   register, which raises rsp_valid. An item yields 1 line byte if plain, 2
//   if escaped, plus BOF/FCS/EOF bytes; the back-end sequencer, one byte per
//   cycle unless the output stalls, sets the rate.
// Reset: clears the queue, sequencer and output valid, CRC to 0xFFFF, extra
//   BOF count to 0.
// rsp_ready low holds the output byte; the queue absorbs up to four more
//   items before req_ready drops.
module sir_async_frame_wrapper_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sir_afw_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sir_afw_pkg::rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [5:0]           csr_data
);
   import sir_afw_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   // classify and CRC each byte on transfer
   sir_afw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push        (push)
   );

   sir_afw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // line byte sequencer; retires an entry on its last line byte
   sir_afw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: bench/tb_sir_async_frame_wrapper_core.sv
module tb_sir_async_frame_wrapper_core;
   timeunit 1ns;
   timeprecision 1ps;

   // Stimulus is driven on the falling edge. Outputs are sampled on the rising edge.
   // Every input byte accepted on req_* is expanded right away into the line bytes
   // it must produce: extra BOFs, BOF, escaped data, escaped FCS and EOF. These
   // go into a FIFO, and each rsp_* transfer is checked against the FIFO head.

   import sir_afw_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;    // output is two stages behind req_*, plus margin
   localparam int HOLD_CYCLES   = 300;  // long rsp_ready hold-off in the pressure test

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_data  = '0;

   // bench copy of the block state
   logic [15:0] frame_crc  = CRC_INIT;
   logic [5:0]  xbof_count = '0;

   rsp_type line_bytes_q[$];   // line bytes still owed by the DUT

   int fail_count    = 0;
   int bytes_in      = 0;
   int frames_closed = 0;
   int lines_checked = 0;
   int cycle_count   = 0;

   // idle/stall mix, in percent; the hold counter forces a long rsp stall
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;

   sir_async_frame_wrapper_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d line bytes outstanding",
                  cycle_count, line_bytes_q.size());
         $display("tb_sir_async_frame_wrapper_core: FAIL");
         $finish;
      end
   end

   function automatic logic roll(input int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // ---------------------------------------------------------------------
   // Line byte predictor
   // ---------------------------------------------------------------------

   // IrDA FCS, reflected 0x8408. Uses the feedback-bit form, one input bit per step.
   function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = acc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ b[k];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic ce_escaped(input logic [7:0] b);
      return b inside {CE_BYTE, BOF_BYTE, EOF_BYTE};
   endfunction

   function automatic void push_line(input logic [7:0] b, input logic eof);
      rsp_type r;
      r.out_byte    = b;
      r.last_of_run = 1'b0;
      r.frame_end   = eof;
      line_bytes_q.push_back(r);
   endfunction

   function automatic void push_escaped(input logic [7:0] b);
      if (ce_escaped(b)) begin
         push_line(CE_BYTE, 1'b0);
         push_line(b ^ ESC_XOR, 1'b0);
      end else begin
         push_line(b, 1'b0);
      end
   endfunction

   // Expand one accepted input byte into its run of line bytes.
   function automatic void wrap_byte(input req_type item);
      rsp_type     tail;
      int          nbof;
      logic [15:0] fcs;
      if (item.first_of_frame) begin
         // counts above 48 saturate
         nbof = (xbof_count > MAX_EXTRA_BOF) ? int'(MAX_EXTRA_BOF) : int'(xbof_count);
         repeat (nbof) push_line(XBOF_BYTE, 1'b0);
         push_line(BOF_BYTE, 1'b0);
         frame_crc = CRC_INIT;
      end
      push_escaped(item.data_byte);
      frame_crc = fcs_update(frame_crc, item.data_byte);
      if (item.last_of_frame) begin
         // FCS goes out complemented, low byte first
         fcs = ~frame_crc;
         push_escaped(fcs[7:0]);
         push_escaped(fcs[15:8]);
         push_line(EOF_BYTE, 1'b1);
         frame_crc = CRC_INIT;
         frames_closed++;
      end
      // Every step yields at least one byte. Flag the last one of this run.
      tail = line_bytes_q.pop_back();
      tail.last_of_run = 1'b1;
      line_bytes_q.push_back(tail);
   endfunction

   // ---------------------------------------------------------------------
   // Response side: ready pattern and checker
   // ---------------------------------------------------------------------

   // A pending hold-off has priority over the random stall mix.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= !roll(rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : line_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         lines_checked++;
         if (line_bytes_q.size() == 0) begin
            $error("unexpected line byte %h (last_of_run %b, frame_end %b)",
                   rsp_payload.out_byte, rsp_payload.last_of_run, rsp_payload.frame_end);
            fail_count++;
         end else begin
            want = line_bytes_q.pop_front();
            if (rsp_payload.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_payload.out_byte);
               fail_count++;
            end
            if (rsp_payload.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b",
                      want.last_of_run, rsp_payload.last_of_run);
               fail_count++;
            end
            if (rsp_payload.frame_end !== want.frame_end) begin
               $error("frame_end: expected %b, got %b", want.frame_end, rsp_payload.frame_end);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Send one frame byte. Random idle cycles come first. Valid then holds
   // until the transfer completes. Returns just after the accepting edge.
   task automatic send_byte(input logic [7:0] d, input logic first, input logic last);
      req_type item;
      item.data_byte      = d;
      item.first_of_frame = first;
      item.last_of_frame  = last;
      @(negedge clock);
      while (roll(req_idle_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      wrap_byte(item);
      bytes_in++;
   endtask

   // Drop valid. Wait until every owed line byte has arrived and the pipe has settled.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (line_bytes_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The CSR is written only while the block is idle.
   task automatic write_bof_count(input logic [5:0] val);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      xbof_count = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random frame content. Weighted toward bytes that need escaping, 0xFF, and the CE and BOF XOR images.
   function automatic logic [7:0] pick_byte();
      if (roll(25)) begin
         case ($urandom_range(5, 0))
            0:       return CE_BYTE;
            1:       return BOF_BYTE;
            2:       return EOF_BYTE;
            3:       return XBOF_BYTE;
            4:       return CE_BYTE ^ ESC_XOR;
            default: return BOF_BYTE ^ ESC_XOR;
         endcase
      end
      return 8'($urandom_range(255, 0));
   endfunction

   // Mostly well-formed frames of 1..8 bytes. Some frames are cut short with no
   // last mark. Some stray bytes carry random marks.
   task automatic send_random_frames(input int n_items);
      int   sent;
      int   len;
      logic cut;
      sent = 0;
      while (sent < n_items) begin
         if (roll(10)) begin
            send_byte(pick_byte(), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            sent++;
         end else begin
            len = $urandom_range(8, 1);
            cut = roll(8);
            for (int k = 0; k < len; k++) begin
               send_byte(pick_byte(), k == 0, (k == len - 1) && !cut);
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset count of zero. Covers stray bytes, one-byte frames, every escaped
   // value, and FCS bytes that themselves need escaping.
   task automatic test_directed_bytes();
      logic [15:0] fcs;
      logic [7:0]  lo_hit;
      logic [7:0]  hi_hit;
      logic        lo_found;
      logic        hi_found;
      // these bytes arrive with no frame start, so they run on from the reset CRC
      send_byte(8'h12, 1'b0, 1'b0);
      send_byte(BOF_BYTE, 1'b0, 1'b1);
      // one-byte frames at the data extremes
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      // a frame that escapes every special byte; the XOR images pass through unchanged
      send_byte(CE_BYTE, 1'b1, 1'b0);
      send_byte(BOF_BYTE, 1'b0, 1'b0);
      send_byte(EOF_BYTE, 1'b0, 1'b0);
      send_byte(CE_BYTE ^ ESC_XOR, 1'b0, 1'b0);
      send_byte(BOF_BYTE ^ ESC_XOR, 1'b0, 1'b0);
      send_byte(EOF_BYTE ^ ESC_XOR, 1'b0, 1'b0);
      send_byte(XBOF_BYTE, 1'b0, 1'b1);
      // find one-byte frames whose FCS low or high byte needs escaping
      lo_found = 1'b0;
      hi_found = 1'b0;
      lo_hit   = '0;
      hi_hit   = '0;
      for (int k = 0; k < 256; k++) begin
         fcs = ~fcs_update(CRC_INIT, 8'(k));
         if (!lo_found && ce_escaped(fcs[7:0])) begin
            lo_hit   = 8'(k);
            lo_found = 1'b1;
         end
         if (!hi_found && ce_escaped(fcs[15:8])) begin
            hi_hit   = 8'(k);
            hi_found = 1'b1;
         end
      end
      send_byte(lo_hit, 1'b1, 1'b1);
      send_byte(hi_hit, 1'b1, 1'b1);
   endtask

   // Extra BOF count at the extremes, including values above 48 that saturate.
   task automatic test_bof_counts();
      write_bof_count(MAX_EXTRA_BOF);
      send_byte(8'hA5, 1'b1, 1'b1);
      write_bof_count(6'd63);
      send_byte(8'h5A, 1'b1, 1'b0);
      send_byte(EOF_BYTE, 1'b0, 1'b1);
      write_bof_count(6'd49);
      send_byte(8'h3C, 1'b1, 1'b1);
      write_bof_count(6'd1);
      send_byte(8'hC3, 1'b1, 1'b1);
      write_bof_count(6'd0);
      send_byte(8'h81, 1'b1, 1'b1);
   endtask

   // Random frames under four idle/stall mixes, each with a new BOF count.
   task automatic test_random_traffic();
      int req_mix[4];
      int rsp_mix[4];
      req_mix = '{0, 59, 0, 37};
      rsp_mix = '{0, 0, 59, 37};
      for (int p = 0; p < 4; p++) begin
         if (p == 3) begin
            write_bof_count(6'($urandom_range(63, 0)));
         end else begin
            write_bof_count(6'($urandom_range(4, 0)));
         end
         req_idle_pct  = req_mix[p];
         rsp_stall_pct = rsp_mix[p];
         send_random_frames(85);
      end
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering bytes.
   // The queue fills and req_ready must drop without losing anything.
   task automatic test_input_backpressure();
      write_bof_count(6'd2);
      hold_left = HOLD_CYCLES;
      send_random_frames(24);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_bytes();
      test_bof_counts();
      test_random_traffic();
      test_input_backpressure();
      wait_idle();

      $display("Run: %0d frame bytes in, %0d frames closed, %0d line bytes checked",
               bytes_in, frames_closed, lines_checked);
      $display("BOF counts 0..63 with saturation, escaped data and FCS, four stall mixes");
      if (fail_count == 0 && line_bytes_q.size() == 0) begin
         $display("tb_sir_async_frame_wrapper_core: PASS");
      end else begin
         $display("%0d mismatches, %0d line bytes never seen", fail_count,
                  line_bytes_q.size());
         $display("tb_sir_async_frame_wrapper_core: FAIL");
      end
      $finish;
   end

endmodule
